// ===== rtl/multi_slot_countdown_timer_bank_assert.svh =====
// Assertion macros used by the timer bank checker.
`ifndef MULTI_SLOT_COUNTDOWN_TIMER_BANK_ASSERT_SVH
`define MULTI_SLOT_COUNTDOWN_TIMER_BANK_ASSERT_SVH

// Same-cycle implication, off during reset.
`define MSCTB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define MSCTB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/msctb_pkg.sv =====
`default_nettype none
package msctb_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int CNT_W         = 32;

    // command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;
    localparam logic [1:0] CMD_STOP  = 2'd3;

    // result kinds
    localparam logic [1:0] EV_ACK  = 2'd0;
    localparam logic [1:0] EV_EXP  = 2'd1;
    localparam logic [1:0] EV_DONE = 2'd2;

    // slot index width, at least one bit
    function automatic int slot_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    // countdown unit result
    typedef struct packed {
        logic [CNT_W-1:0] cnt;     // value to write back
        logic             expire;  // count reached zero this tick
        logic             reload;  // expired and periodic
    } t_dec_res;

endpackage
`default_nettype wire

// ===== rtl/multi_slot_countdown_timer_bank.sv =====
// Multi-slot countdown timer bank.
// Input channel (i_in_valid / o_in_ready) takes one command beat: tick, add,
// start or stop, with slot, interval and auto_reload. Output channel
// (o_out_valid / i_out_ready) returns result beats: acknowledges, expiry
// events and tick-done events; o_last marks the final beat of a command.
// Add, start and stop: one acknowledge beat, visible the cycle after accept;
// the block is ready again as soon as that beat can leave.
// Tick: the ms counter increments, then a sequencer walks the linked slots in
// the order they were added. A stopped slot is skipped in the read state; a
// running slot goes through a slot RAM read, then the shared countdown unit
// and write-back.
// Each expiry emits one beat; the done beat (o_last = 1) closes the tick.
// A single output register decouples the sides. When the receiver stalls,
// the walk holds at the expiring slot and no input is taken until the
// register frees up; nothing is dropped or repeated.
// Reset (synchronous, active low) clears the ms counter, link list and all
// flags; the count and interval RAMs hold junk until a start writes them.
`default_nettype none
module multi_slot_countdown_timer_bank #(
    parameter int NUM_SLOTS = msctb_pkg::NUM_SLOTS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // command channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [1:0]           i_command,
    input  wire logic [3:0]           i_slot,
    input  wire logic [31:0]          i_interval,
    input  wire logic                 i_auto_reload,
    // result channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [1:0]                o_event_kind,
    output logic [3:0]                o_event_slot,
    output logic                      o_accepted,
    output logic                      o_reloaded,
    output logic signed [31:0]        o_tick_count,
    output logic                      o_last
);
    import msctb_pkg::*;

    localparam int SW = slot_w(NUM_SLOTS);
    localparam int LW = $clog2(NUM_SLOTS + 1);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a command
    localparam logic [1:0] S_RD   = 2'd1;  // pick next linked slot, read RAM
    localparam logic [1:0] S_EX   = 2'd2;  // countdown, write back, emit expiry
    localparam logic [1:0] S_FIN  = 2'd3;  // emit tick-done beat

    logic [1:0]           r_state, n_state;
    logic [LW-1:0]        r_idx, n_idx;        // walk position in tick order
    logic [LW-1:0]        r_total;             // linked slot count
    logic [SW-1:0]        r_cur, n_cur;        // slot under countdown
    logic [CNT_W-1:0]     r_tick_cnt;
    logic [NUM_SLOTS-1:0] r_linked;
    logic [NUM_SLOTS-1:0] r_running;
    logic [NUM_SLOTS-1:0] r_periodic;
    logic [SW-1:0]        r_order [NUM_SLOTS]; // tick order, valid below r_total

    // output register
    logic                 r_o_valid;
    logic [1:0]           r_o_kind;
    logic [3:0]           r_o_slot;
    logic                 r_o_acc;
    logic                 r_o_rel;
    logic signed [31:0]   r_o_cnt;
    logic                 r_o_last;

    logic                 w_out_free;
    logic                 w_in_acc;
    logic [SW-1:0]        w_slot_idx;
    logic                 w_slot_ok;
    logic                 w_add_ok;
    logic [SW-1:0]        w_order_slot;

    // beat to load into the output register
    logic                 w_load;
    logic [1:0]           w_kind;
    logic [3:0]           w_eslot;
    logic                 w_acc;
    logic                 w_rel;
    logic [CNT_W-1:0]     w_cnt;
    logic                 w_last;

    // slot RAM control
    logic                 w_re;
    logic                 w_we_rem;
    logic                 w_we_rel;
    logic [SW-1:0]        w_waddr;
    logic [CNT_W-1:0]     w_wdata;
    logic [CNT_W-1:0]     w_rd_rem;
    logic [CNT_W-1:0]     w_rd_rel;

    logic                 w_tick_inc;
    logic                 w_run_clr;
    t_dec_res             w_dec;

    assign w_out_free   = !r_o_valid || i_out_ready;
    assign o_in_ready   = (r_state == S_IDLE) && w_out_free;
    assign w_in_acc     = i_in_valid && o_in_ready;
    assign w_slot_idx   = SW'(i_slot);
    assign w_slot_ok    = (32'(i_slot) < 32'(NUM_SLOTS));
    assign w_add_ok     = w_slot_ok && !r_linked[w_slot_idx] && (r_total < LW'(NUM_SLOTS));
    assign w_order_slot = r_order[r_idx[SW-1:0]];

    msctb_slot_mem #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_mem (
        .i_clk    (i_clk),
        .i_we_rem (w_we_rem),
        .i_we_rel (w_we_rel),
        .i_waddr  (w_waddr),
        .i_wdata  (w_wdata),
        .i_re     (w_re),
        .i_raddr  (w_order_slot),
        .o_rd_rem (w_rd_rem),
        .o_rd_rel (w_rd_rel)
    );

    // shared countdown unit, one slot per use
    msctb_dec_unit u_dec (
        .i_cnt        (w_rd_rem),
        .i_reload_val (w_rd_rel),
        .i_periodic   (r_periodic[r_cur]),
        .o_res        (w_dec)
    );

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_cur      = r_cur;
        w_re       = 1'b0;
        w_we_rem   = 1'b0;
        w_we_rel   = 1'b0;
        w_waddr    = r_cur;
        w_wdata    = w_dec.cnt;
        w_tick_inc = 1'b0;
        w_run_clr  = 1'b0;
        w_load     = 1'b0;
        w_kind     = EV_ACK;
        w_eslot    = i_slot;
        w_acc      = 1'b0;
        w_rel      = 1'b0;
        w_cnt      = '0;
        w_last     = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_command == CMD_TICK) begin
                        w_tick_inc = 1'b1;
                        n_idx      = '0;
                        n_state    = S_RD;
                    end else begin
                        // acknowledge right away
                        w_load = 1'b1;
                        w_acc  = (i_command == CMD_ADD) && w_add_ok;
                        if ((i_command == CMD_START) && w_slot_ok) begin
                            w_we_rem = 1'b1;
                            w_we_rel = 1'b1;
                            w_waddr  = w_slot_idx;
                            w_wdata  = i_interval;
                        end
                    end
                end
            end
            S_RD: begin
                if (r_idx == r_total) begin
                    n_state = S_FIN;
                end else if (r_running[w_order_slot]) begin
                    w_re    = 1'b1;
                    n_cur   = w_order_slot;
                    n_state = S_EX;
                end else begin
                    n_idx = r_idx + LW'(1);
                end
            end
            S_EX: begin
                // an expiry needs the output register; hold until it frees
                if (!w_dec.expire || w_out_free) begin
                    w_we_rem = 1'b1;
                    n_idx    = r_idx + LW'(1);
                    n_state  = S_RD;
                    if (w_dec.expire) begin
                        w_load    = 1'b1;
                        w_kind    = EV_EXP;
                        w_eslot   = 4'(r_cur);
                        w_rel     = w_dec.reload;
                        w_cnt     = r_tick_cnt;
                        w_last    = 1'b0;
                        w_run_clr = !w_dec.reload;
                    end
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    w_kind  = EV_DONE;
                    w_eslot = '0;
                    w_cnt   = r_tick_cnt;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_cur      <= '0;
            r_tick_cnt <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_cur   <= n_cur;
            if (w_tick_inc) begin
                r_tick_cnt <= r_tick_cnt + CNT_W'(1);
            end
        end
    end

    // per-slot flags and link count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_linked   <= '0;
            r_running  <= '0;
            r_periodic <= '0;
            r_total    <= '0;
        end else begin
            if (w_in_acc && w_slot_ok) begin
                unique case (i_command)
                    CMD_ADD: begin
                        if (w_add_ok) begin
                            r_linked[w_slot_idx] <= 1'b1;
                            r_total              <= r_total + LW'(1);
                        end
                    end
                    CMD_START: begin
                        r_periodic[w_slot_idx] <= i_auto_reload;
                        r_running[w_slot_idx]  <= 1'b1;
                    end
                    CMD_STOP: begin
                        r_running[w_slot_idx] <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            if (w_run_clr) begin
                r_running[r_cur] <= 1'b0;
            end
        end
    end

    // tick order list, appended on add
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_command == CMD_ADD) && w_add_ok) begin
            r_order[r_total[SW-1:0]] <= w_slot_idx;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_load) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_kind <= w_kind;
            r_o_slot <= w_eslot;
            r_o_acc  <= w_acc;
            r_o_rel  <= w_rel;
            r_o_cnt  <= signed'(w_cnt);
            r_o_last <= w_last;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_event_kind = r_o_kind;
    assign o_event_slot = r_o_slot;
    assign o_accepted   = r_o_acc;
    assign o_reloaded   = r_o_rel;
    assign o_tick_count = r_o_cnt;
    assign o_last       = r_o_last;

endmodule
`default_nettype wire

// ===== rtl/msctb_slot_mem.sv =====
`default_nettype none
module msctb_slot_mem #(
    parameter int NUM_SLOTS = msctb_pkg::NUM_SLOTS_DEF
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_we_rem,
    input  wire logic                                       i_we_rel,
    input  wire logic [msctb_pkg::slot_w(NUM_SLOTS)-1:0]    i_waddr,
    input  wire logic [msctb_pkg::CNT_W-1:0]                i_wdata,
    input  wire logic                                       i_re,
    input  wire logic [msctb_pkg::slot_w(NUM_SLOTS)-1:0]    i_raddr,
    output logic      [msctb_pkg::CNT_W-1:0]                o_rd_rem,
    output logic      [msctb_pkg::CNT_W-1:0]                o_rd_rel
);
    import msctb_pkg::*;

    logic [CNT_W-1:0] r_rem_mem [NUM_SLOTS];
    logic [CNT_W-1:0] r_rel_mem [NUM_SLOTS];

    // remaining count
    always_ff @(posedge i_clk) begin
        if (i_we_rem) begin
            r_rem_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rd_rem <= r_rem_mem[i_raddr];
        end
    end

    // reload interval, written by start only
    always_ff @(posedge i_clk) begin
        if (i_we_rel) begin
            r_rel_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rd_rel <= r_rel_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/msctb_dec_unit.sv =====
`default_nettype none
module msctb_dec_unit (
    input  wire logic [msctb_pkg::CNT_W-1:0] i_cnt,
    input  wire logic [msctb_pkg::CNT_W-1:0] i_reload_val,
    input  wire logic                        i_periodic,
    output msctb_pkg::t_dec_res              o_res
);
    import msctb_pkg::*;

    logic             w_nz;
    logic [CNT_W-1:0] w_dec;

    // saturating decrement, zero test on the result
    assign w_nz  = (i_cnt != '0);
    assign w_dec = w_nz ? (i_cnt - CNT_W'(1)) : '0;

    always_comb begin
        o_res.expire = (w_dec == '0);
        o_res.reload = o_res.expire && i_periodic;
        if (o_res.reload) begin
            o_res.cnt = i_reload_val;
        end else begin
            o_res.cnt = w_dec;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/msctb_checker.sv =====
`default_nettype none
`include "multi_slot_countdown_timer_bank_assert.svh"
module msctb_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic [1:0]         i_command,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic [1:0]         o_event_kind,
    input wire logic               o_accepted,
    input wire logic               o_last
);
    import msctb_pkg::*;

    // a stalled result beat stays up
    `MSCTB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready, o_out_valid, "result beat dropped while stalled")

    // ready only when the output register can take the acknowledge
    `MSCTB_ASSERT_NOW(a_ready_room, i_clk, i_rst_n,
        o_in_ready, !o_out_valid || i_out_ready, "ready while output register blocked")

    // add, start and stop acknowledge on the next cycle
    `MSCTB_ASSERT_NEXT(a_ack_next, i_clk, i_rst_n,
        i_in_valid && o_in_ready && (i_command != CMD_TICK),
        o_out_valid && (o_event_kind == EV_ACK) && o_last, "missing acknowledge")

    // an expiry beat never closes a command
    `MSCTB_ASSERT_NOW(a_exp_not_last, i_clk, i_rst_n,
        o_out_valid && (o_event_kind == EV_EXP), !o_last && !o_accepted, "bad expiry beat")

endmodule

bind multi_slot_countdown_timer_bank msctb_checker u_msctb_checker (.*);
`default_nettype wire

// ===== test/tb_multi_slot_countdown_timer_bank.sv =====
`default_nettype none
module tb_multi_slot_countdown_timer_bank;
    timeunit 1ns;
    timeprecision 1ps;

    import msctb_pkg::*;

    // Run shape
    localparam int SLOT_COUNT   = NUM_SLOTS_DEF;
    localparam int RANDOM_BEATS = 340;   // directed part adds about twenty more
    localparam int DRAIN_CYCLES = 60;    // quiet time watched for stray beats after the drain
    localparam int STALL_LIMIT  = 3000;  // cycles with no beat on either side

    // One result beat, packed at the port widths
    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  slot;
        logic        accepted;
        logic        reloaded;
        logic [31:0] count;
        logic        last;
    } t_timer_event;

    // Shadow copy of the timer bank plus the queue of events it still owes.
    class t_timer_bank_scoreboard;
        logic [31:0]             ms_count;
        logic [31:0]             remaining [SLOT_COUNT];
        logic [31:0]             reload_val [SLOT_COUNT];
        logic [SLOT_COUNT-1:0]   periodic;
        logic [SLOT_COUNT-1:0]   running;
        logic [SLOT_COUNT-1:0]   expired;
        logic [SLOT_COUNT-1:0]   linked;
        logic [3:0]              order [SLOT_COUNT];
        int                      linked_total;
        t_timer_event            due_events [$];
        int                      mismatches;
        int                      beats_checked;
        int                      expiries_due;
        int                      ticks_sent;
        int                      cmds_sent;

        function new();
            ms_count      = '0;
            periodic      = '0;
            running       = '0;
            expired       = '0;
            linked        = '0;
            linked_total  = 0;
            mismatches    = 0;
            beats_checked = 0;
            expiries_due  = 0;
            ticks_sent    = 0;
            cmds_sent     = 0;
            foreach (remaining[i]) begin
                remaining[i]  = '0;
                reload_val[i] = '0;
                order[i]      = '0;
            end
        endfunction

        function void push_event(logic [1:0] kind, logic [3:0] s, logic acc, logic rel,
                                 logic [31:0] cnt, logic last);
            t_timer_event ev;
            ev.kind     = kind;
            ev.slot     = s;
            ev.accepted = acc;
            ev.reloaded = rel;
            ev.count    = cnt;
            ev.last     = last;
            due_events.push_back(ev);
        endfunction

        // Called once per accepted command beat; queues everything it causes.
        function void apply_command(logic [1:0] cmd, logic [3:0] s, logic [31:0] ivl,
                                    logic ar);
            logic [3:0] t;
            logic       rel;
            logic       acc;
            cmds_sent++;
            if (cmd == CMD_TICK) begin
                ticks_sent++;
                ms_count = ms_count + 32'd1;
                // walk in link order; only running slots count down
                for (int i = 0; i < linked_total; i++) begin
                    t = order[i];
                    if (running[t]) begin
                        if (remaining[t] != 32'd0)
                            remaining[t] = remaining[t] - 32'd1;
                        if (remaining[t] == 32'd0) begin
                            rel = periodic[t];
                            if (rel)
                                remaining[t] = reload_val[t];
                            else
                                running[t] = 1'b0;
                            expired[t] = 1'b1;
                            expiries_due++;
                            push_event(EV_EXP, t, 1'b0, rel, ms_count, 1'b0);
                        end
                    end
                end
                push_event(EV_DONE, 4'd0, 1'b0, 1'b0, ms_count, 1'b1);
            end else begin
                acc = 1'b0;
                if (int'(s) < SLOT_COUNT) begin
                    case (cmd)
                        CMD_ADD: begin
                            if (!linked[s] && linked_total < SLOT_COUNT) begin
                                linked[s]           = 1'b1;
                                order[linked_total] = s;
                                linked_total++;
                                acc = 1'b1;
                            end
                        end
                        CMD_START: begin
                            reload_val[s] = ivl;
                            remaining[s]  = ivl;
                            periodic[s]   = ar;
                            expired[s]    = 1'b0;
                            running[s]    = 1'b1;
                        end
                        default: begin
                            running[s] = 1'b0;
                        end
                    endcase
                end
                push_event(EV_ACK, s, acc, 1'b0, 32'd0, 1'b1);
            end
        endfunction

        task flag_mismatch(string msg);
            mismatches++;
            $display("MISMATCH @%0t: %s", $time, msg);
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                flag_mismatch($sformatf("%s got 0x%0h want 0x%0h (beat %0d)",
                                        name, got, want, beats_checked));
        endtask

        task check_event(t_timer_event got);
            t_timer_event want;
            if (due_events.size() == 0) begin
                flag_mismatch($sformatf("stray beat kind %0d slot %0d count %0d",
                                        got.kind, got.slot, got.count));
                return;
            end
            want = due_events.pop_front();
            beats_checked++;
            compare_field("event_kind", 32'(got.kind), 32'(want.kind));
            compare_field("event_slot", 32'(got.slot), 32'(want.slot));
            compare_field("accepted", 32'(got.accepted), 32'(want.accepted));
            compare_field("reloaded", 32'(got.reloaded), 32'(want.reloaded));
            compare_field("tick_count", got.count, want.count);
            compare_field("last", 32'(got.last), 32'(want.last));
        endtask
    endclass

    // DUT hookup; every input starts at a known value
    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic [1:0]         i_command     = CMD_TICK;
    logic [3:0]         i_slot        = 4'd0;
    logic [31:0]        i_interval    = 32'd0;
    logic               i_auto_reload = 1'b0;
    logic               i_out_ready   = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic [1:0]         o_event_kind;
    logic [3:0]         o_event_slot;
    logic               o_accepted;
    logic               o_reloaded;
    logic signed [31:0] o_tick_count;
    logic               o_last;

    t_timer_bank_scoreboard book;
    bit                     calm = 1'b0;   // no idling on either side while set
    int                     idle_cycles = 0;

    multi_slot_countdown_timer_bank #(.NUM_SLOTS(SLOT_COUNT)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_slot        (i_slot),
        .i_interval    (i_interval),
        .i_auto_reload (i_auto_reload),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_event_kind  (o_event_kind),
        .o_event_slot  (o_event_slot),
        .o_accepted    (o_accepted),
        .o_reloaded    (o_reloaded),
        .o_tick_count  (o_tick_count),
        .o_last        (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Gap length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Drive one command beat; returns once it has been taken.
    // Payload changes on the falling edge, ready is sampled on the rising edge.
    task automatic send_beat(logic [1:0] cmd, logic [3:0] s, logic [31:0] ivl, logic ar);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_slot        <= s;
        i_interval    <= ivl;
        i_auto_reload <= ar;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        book.apply_command(cmd, s, ivl, ar);
    endtask

    // Random start: mostly short intervals so slots actually fire,
    // some medium, a few full-width ones to toggle the upper bits.
    task automatic send_random_start(logic [3:0] s);
        int          r;
        logic [31:0] ivl;
        r = $urandom_range(0, 99);
        if (r < 60)
            ivl = $urandom_range(0, 4);
        else if (r < 85)
            ivl = $urandom_range(5, 40);
        else
            ivl = $urandom();
        send_beat(CMD_START, s, ivl, 1'($urandom_range(0, 1)));
    endtask

    // Result side back-pressure: random stalls, none while calm
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                if (!calm && $urandom_range(0, 99) < 25)
                    stall_left = ($urandom_range(0, 9) < 9) ? $urandom_range(1, 3)
                                                             : $urandom_range(10, 40);
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        t_timer_event got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.kind     = o_event_kind;
            got.slot     = o_event_slot;
            got.accepted = o_accepted;
            got.reloaded = o_reloaded;
            got.count    = o_tick_count;
            got.last     = o_last;
            book.check_event(got);
        end
    end

    // Watchdog: any beat on either channel restarts the count
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: %0d cycles without a beat, %0d results outstanding",
                         idle_cycles, book.due_events.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        int          n;
        int          pick;
        logic [3:0]  s;
        book = new();

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed part ----
        send_beat(CMD_TICK, 4'd0, 32'd0, 1'b0);          // tick with empty link list
        send_beat(CMD_ADD, 4'd0, 32'd0, 1'b0);
        send_beat(CMD_ADD, 4'd15, 32'hFFFF_FFFF, 1'b1);
        send_beat(CMD_ADD, 4'd0, 32'd0, 1'b0);           // already linked, not accepted
        send_beat(CMD_STOP, 4'd3, 32'd0, 1'b0);          // stop of an idle, unlinked slot
        send_beat(CMD_START, 4'd0, 32'd0, 1'b1);         // zero interval, periodic
        send_beat(CMD_START, 4'd15, 32'd1, 1'b0);        // one-shot, fires on next tick
        send_beat(CMD_START, 4'd7, 32'd2, 1'b1);         // started before it is linked
        send_beat(CMD_TICK, 4'd0, 32'd0, 1'b0);
        send_beat(CMD_TICK, 4'd15, 32'hFFFF_FFFF, 1'b1); // payload ignored on tick
        send_beat(CMD_ADD, 4'd7, 32'd0, 1'b0);           // now slot 7 joins the walk
        send_beat(CMD_TICK, 4'd0, 32'd0, 1'b0);
        send_beat(CMD_TICK, 4'd0, 32'd0, 1'b0);          // slot 7 reloads
        send_beat(CMD_START, 4'd15, 32'hFFFF_FFFF, 1'b1);
        send_beat(CMD_START, 4'd3, 32'hFFFF_FFFF, 1'b0);
        send_beat(CMD_ADD, 4'd3, 32'd0, 1'b0);
        send_beat(CMD_STOP, 4'd0, 32'd0, 1'b0);
        send_beat(CMD_TICK, 4'd0, 32'd0, 1'b0);
        send_beat(CMD_STOP, 4'd15, 32'd0, 1'b0);
        send_beat(CMD_START, 4'd15, 32'd0, 1'b0);        // zero interval one-shot
        send_beat(CMD_TICK, 4'd0, 32'd0, 1'b0);
        send_beat(CMD_TICK, 4'd0, 32'd0, 1'b0);

        // ---- random part ----
        // Ticks dominate; the link list fills up early so later adds mostly
        // come back not accepted, and starts keep reloading live slots.
        for (n = 0; n < RANDOM_BEATS; n++) begin
            calm = (n >= 140 && n < 200);
            pick = $urandom_range(0, 99);
            s    = 4'($urandom_range(0, SLOT_COUNT - 1));
            if (pick < 45)
                send_beat(CMD_TICK, s, $urandom(), 1'($urandom_range(0, 1)));
            else if (pick < 60)
                send_beat(CMD_ADD, s, $urandom(), 1'($urandom_range(0, 1)));
            else if (pick < 88)
                send_random_start(s);
            else
                send_beat(CMD_STOP, s, $urandom(), 1'($urandom_range(0, 1)));
        end
        calm = 1'b0;

        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // drain what is still owed, then watch for stray beats a while
        while (book.due_events.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d command beats, %0d of them ticks, %0d slots linked.",
                 book.cmds_sent, book.ticks_sent, book.linked_total);
        $display("Checked %0d result beats including %0d slot expiries; %0d mismatches.",
                 book.beats_checked, book.expiries_due, book.mismatches);
        if (book.mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/msctb_pkg.sv
rtl/msctb_slot_mem.sv
rtl/msctb_dec_unit.sv
rtl/multi_slot_countdown_timer_bank.sv
rtl/msctb_checker.sv
test/tb_multi_slot_countdown_timer_bank.sv
